// ----- rtl/midi_note_off_framer_crc8_macros.svh -----
// ---------------------------------------------------------------------------
// MIDI note-off framer assertion macros
// Assertion helpers for the framer; they reduce to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef MIDI_NOTE_OFF_FRAMER_CRC8_MACROS_SVH
`define MIDI_NOTE_OFF_FRAMER_CRC8_MACROS_SVH
`ifndef SYNTHESIS
`define MNOFC8_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("framer assertion failed");
`define MNOFC8_NEVER(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("framer forbidden condition seen");
`else
`define MNOFC8_ASSERT(name, prop)
`define MNOFC8_NEVER(name, cond)
`endif
`endif

// ----- rtl/mnofc8_pkg.sv -----
// ---------------------------------------------------------------------------
// MIDI note-off framer package
// Shared codes, the stage-to-stage item type and the CRC-8 byte update.
// ---------------------------------------------------------------------------
package mnofc8_pkg;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic       REG_CRC_POLY     = 1'b0;
    localparam logic [7:0] CRC_POLY_RESET   = 8'h07;
    localparam logic [7:0] CRC_SEED         = 8'hFF;
    localparam logic [7:0] STATUS_BASE      = 8'h80;
    localparam logic [7:0] STATUS_HEADER    = 8'h08;
    localparam logic [7:0] STATUS_PAIR      = 8'h04;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] tag;
        logic [7:0] length;
        logic [7:0] data;
        logic [7:0] seed_crc;
    } item_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/mnofc8_in_stage.sv -----
// ---------------------------------------------------------------------------
// MIDI note-off framer input stage
// Registers the incoming word, forms the header tag and length, and runs
// the first CRC-8 update of a start item over the tag.
// ---------------------------------------------------------------------------
module mnofc8_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          crc_poly,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_mode,
    input  logic [6:0]          in_tag,
    input  logic [8:0]          in_size,
    input  logic [7:0]          in_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output mnofc8_pkg::item_t   out_item
);

    logic              valid_reg;
    logic              valid_next;
    mnofc8_pkg::item_t item_reg;
    mnofc8_pkg::item_t item_next;
    logic              accept;
    logic              short_size;
    logic [8:0]        size_m1;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        short_size = (in_size == 9'd0) || (in_size == 9'd1);
        size_m1    = in_size - 9'd1;
        item_next.mode = in_mode;
        item_next.data = in_byte;
        item_next.tag  = {short_size, in_tag};
        if (in_size == 9'd1) begin
            item_next.length = in_byte;
        end else if (in_size == 9'd0) begin
            item_next.length = 8'd0;
        end else begin
            item_next.length = size_m1[7:0];
        end
        item_next.seed_crc = mnofc8_pkg::crc_feed(mnofc8_pkg::CRC_SEED,
                                                  item_next.tag, crc_poly);
        if (accept && (in_mode != mnofc8_pkg::MODE_NONE)) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- rtl/mnofc8_frame_stage.sv -----
// ---------------------------------------------------------------------------
// MIDI note-off framer message stage
// Holds the running CRC-8 and the byte pairer, and builds each three-byte
// message into the output register.
// ---------------------------------------------------------------------------
module mnofc8_frame_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          crc_poly,
    input  logic                in_valid,
    output logic                in_ready,
    input  mnofc8_pkg::item_t   in_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_status,
    output logic [6:0]          m_note,
    output logic [6:0]          m_velocity,
    output logic                m_last
);

    logic [7:0] crc_val_reg;
    logic [7:0] crc_next;
    logic       held_valid_reg;
    logic       held_valid_next;
    logic [7:0] held_byte_reg;
    logic [7:0] held_byte_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] status_reg;
    logic [7:0] status_next;
    logic [6:0] note_reg;
    logic [6:0] note_next;
    logic [6:0] velocity_reg;
    logic [6:0] velocity_next;
    logic       last_reg;
    logic       last_next;
    logic       advance;
    logic       emit;
    logic [7:0] feed_crc;
    logic [7:0] feed_byte;
    logic [7:0] crc_fed;
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] flags;

    assign in_ready   = !m_valid_reg || m_ready;
    assign advance    = in_valid && in_ready;
    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_note     = note_reg;
    assign m_velocity = velocity_reg;
    assign m_last     = last_reg;

    always_comb begin
        if (in_item.mode == mnofc8_pkg::MODE_START) begin
            feed_crc  = in_item.seed_crc;
            feed_byte = in_item.length;
        end else begin
            feed_crc  = crc_val_reg;
            feed_byte = in_item.data;
        end
        crc_fed         = mnofc8_pkg::crc_feed(feed_crc, feed_byte, crc_poly);
        crc_next        = crc_val_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        emit            = 1'b0;
        first           = held_byte_reg;
        second          = in_item.data;
        flags           = 8'd0;
        last_next       = 1'b0;
        case (in_item.mode)
            mnofc8_pkg::MODE_START: begin
                crc_next        = crc_fed;
                held_valid_next = 1'b0;
                emit            = 1'b1;
                first           = in_item.tag;
                second          = in_item.length;
                flags           = mnofc8_pkg::STATUS_HEADER;
            end
            mnofc8_pkg::MODE_DATA: begin
                crc_next        = crc_fed;
                held_valid_next = !held_valid_reg;
                held_byte_next  = in_item.data;
                emit            = held_valid_reg;
            end
            mnofc8_pkg::MODE_FINISH: begin
                held_valid_next = 1'b0;
                emit            = 1'b1;
                last_next       = 1'b1;
                if (held_valid_reg) begin
                    second = crc_val_reg;
                end else begin
                    first  = crc_val_reg;
                    second = 8'd0;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        status_next   = mnofc8_pkg::STATUS_BASE | mnofc8_pkg::STATUS_PAIR | flags
                      | {6'd0, first[7], second[7]};
        note_next     = first[6:0];
        velocity_next = second[6:0];
        if (advance && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_val_reg    <= mnofc8_pkg::CRC_SEED;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= 8'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                crc_val_reg    <= crc_next;
                held_valid_reg <= held_valid_next;
                held_byte_reg  <= held_byte_next;
            end
        end
        if (advance && emit) begin
            status_reg   <= status_next;
            note_reg     <= note_next;
            velocity_reg <= velocity_next;
            last_reg     <= last_next;
        end
    end

endmodule

// ----- rtl/midi_note_off_framer_crc8.sv -----
// ---------------------------------------------------------------------------
// MIDI note-off framer with CRC-8
// Frames command payloads as three-byte note-off messages with a CRC-8.
// ---------------------------------------------------------------------------
// The block takes one word per clock unless the output stalls it. Words
// pass the input register, which forms the header and runs the CRC-8
// update over the tag, and then the message register, which runs the one
// CRC-8 update over the length or data byte and builds the message. Data
// words that only fill the byte pairer give no message. The CRC polynomial
// lives at byte address 0 of the register port. The user must see that it is
// written only while no word is in flight; the block does not enforce this.
`include "midi_note_off_framer_crc8_macros.svh"

module midi_note_off_framer_crc8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command_tag [6:0], payload_size [15:7], byte_value [23:16]
    input  logic [23:0] s_tdata,
    // mode [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status_byte [7:0], note_byte [14:8], velocity_byte [21:15]
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    logic              poly_sel;
    logic [7:0]        crc_poly_reg;
    logic              cfg_write;
    logic              mid_valid;
    logic              mid_ready;
    mnofc8_pkg::item_t mid_item;
    logic [7:0]        status;
    logic [6:0]        note;
    logic [6:0]        velocity;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign poly_sel  = (paddr[2] == mnofc8_pkg::REG_CRC_POLY);
    assign prdata    = poly_sel ? {24'd0, crc_poly_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_poly_reg <= mnofc8_pkg::CRC_POLY_RESET;
        end else if (cfg_write && poly_sel) begin
            crc_poly_reg <= pwdata[7:0];
        end
    end

    mnofc8_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .crc_poly  (crc_poly_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_tag    (s_tdata[6:0]),
        .in_size   (s_tdata[15:7]),
        .in_byte   (s_tdata[23:16]),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_item  (mid_item)
    );

    mnofc8_frame_stage u_frame_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .crc_poly   (crc_poly_reg),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .in_item    (mid_item),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_status   (status),
        .m_note     (note),
        .m_velocity (velocity),
        .m_last     (m_tlast)
    );

    assign m_tdata = {2'd0, velocity, note, status};

    `MNOFC8_ASSERT(a_status_form, m_tvalid |-> (m_tdata[7:4] == 4'h8) && m_tdata[2])
    `MNOFC8_NEVER(a_header_not_last, m_tvalid && m_tdata[3] && m_tlast)
    `MNOFC8_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready)
    `MNOFC8_ASSERT(a_mid_drains, (mid_valid && !m_tvalid) |-> mid_ready)

endmodule

// ----- sim/midi_note_off_framer_crc8_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MIDI note-off framer testbench
// Drives start, data and finish words into the framer, predicts each framed
// message with its own CRC-8 and byte pairing, and compares every message
// field by field. The CRC polynomial is changed between phases over the
// register port, extremes included.
// ---------------------------------------------------------------------------
module midi_note_off_framer_crc8_tb;

    localparam int         HALF_PERIOD = 6;
    localparam int         CYCLE_LIMIT = 100000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [2:0] ADDR_POLY   = {mnofc8_pkg::REG_CRC_POLY, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] velocity;
        logic       last;
    } note_msg_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // command_tag [6:0], payload_size [15:7], byte_value [23:16]
    logic [23:0] s_tdata  = '0;
    // mode [1:0]
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status_byte [7:0], note_byte [14:8], velocity_byte [21:15]
    logic [23:0] m_tdata;
    logic        m_tlast;

    logic [7:0]  crc_poly   = mnofc8_pkg::CRC_POLY_RESET;
    logic [7:0]  crc_state  = mnofc8_pkg::CRC_SEED;
    logic        held_valid = 1'b0;
    logic [7:0]  held_byte  = '0;
    note_msg_t   expected_msgs[$];
    int          errors      = 0;
    int          cycle_count = 0;
    bit          steady      = 1'b0;

    midi_note_off_framer_crc8 i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) r = r[7] ? ((r << 1) ^ crc_poly) : (r << 1);
        return r;
    endfunction

    function automatic note_msg_t pack_msg(input logic [7:0] first, input logic [7:0] second,
                                           input logic [7:0] flags, input logic last);
        note_msg_t m;
        m.status   = mnofc8_pkg::STATUS_BASE | flags | mnofc8_pkg::STATUS_PAIR
                   | {6'b0, first[7], second[7]};
        m.note     = first[6:0];
        m.velocity = second[6:0];
        m.last     = last;
        return m;
    endfunction

    task automatic predict_message(input logic [1:0] mode, input logic [6:0] tag,
                                   input logic [8:0] size, input logic [7:0] bval);
        logic [7:0] tag8;
        logic [7:0] length;
        logic [8:0] size_less;
        tag8 = {1'b0, tag};
        size_less = size - 9'd1;
        case (mode)
            mnofc8_pkg::MODE_START: begin
                if (size <= 9'd1) begin
                    tag8[7] = 1'b1;
                    length = (size == 9'd1) ? bval : 8'h00;
                end else begin
                    length = size_less[7:0];
                end
                held_valid = 1'b0;
                expected_msgs.push_back(pack_msg(tag8, length,
                                                 mnofc8_pkg::STATUS_HEADER, 1'b0));
                crc_state = crc8_step(crc8_step(mnofc8_pkg::CRC_SEED, tag8), length);
            end
            mnofc8_pkg::MODE_DATA: begin
                crc_state = crc8_step(crc_state, bval);
                if (!held_valid) begin
                    held_byte = bval;
                    held_valid = 1'b1;
                end else begin
                    expected_msgs.push_back(pack_msg(held_byte, bval, 8'h00, 1'b0));
                    held_valid = 1'b0;
                end
            end
            mnofc8_pkg::MODE_FINISH: begin
                if (held_valid) begin
                    expected_msgs.push_back(pack_msg(held_byte, crc_state, 8'h00, 1'b1));
                end else begin
                    expected_msgs.push_back(pack_msg(crc_state, 8'h00, 8'h00, 1'b1));
                end
                held_valid = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_word(input logic [1:0] mode, input logic [6:0] tag,
                             input logic [8:0] size, input logic [7:0] bval);
        while (!steady && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bval, size, tag};
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_message(mode, tag, size, bval);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_msgs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_POLY) crc_poly = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_POLY;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[7:0] !== crc_poly) begin
            $error("crc_polynomial: expected %h, got %h", crc_poly, prdata[7:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge aclk) begin
        note_msg_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_msgs.size() == 0) begin
                $error("message with none expected: tdata %h, tlast %b", m_tdata, m_tlast);
                errors++;
            end else begin
                want = expected_msgs.pop_front();
                if (m_tdata[7:0] !== want.status) begin
                    $error("status_byte: expected %h, got %h", want.status, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[14:8] !== want.note) begin
                    $error("note_byte: expected %h, got %h", want.note, m_tdata[14:8]);
                    errors++;
                end
                if (m_tdata[21:15] !== want.velocity) begin
                    $error("velocity_byte: expected %h, got %h", want.velocity,
                           m_tdata[21:15]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Data and finish words straight after reset work on the reset CRC state.
    task automatic test_no_start();
        send_word(mnofc8_pkg::MODE_DATA, 7'h00, 9'd0, 8'hA5);
        send_word(mnofc8_pkg::MODE_FINISH, 7'h00, 9'd0, 8'h00);
        send_word(mnofc8_pkg::MODE_FINISH, 7'h7F, 9'h1FF, 8'hFF);
    endtask

    // Sizes zero and one set tag bit 7; sizes above 256 wrap the length.
    task automatic test_start_sizes();
        send_word(mnofc8_pkg::MODE_START, 7'h7F, 9'd0, 8'h3C);
        send_word(mnofc8_pkg::MODE_START, 7'h00, 9'd1, 8'hFF);
        send_word(mnofc8_pkg::MODE_START, 7'h15, 9'd2, 8'h00);
        send_word(mnofc8_pkg::MODE_START, 7'h6A, 9'd256, 8'h81);
        send_word(mnofc8_pkg::MODE_START, 7'h40, 9'd257, 8'h7E);
        send_word(mnofc8_pkg::MODE_START, 7'h7F, 9'h1FF, 8'hFF);
        send_word(mnofc8_pkg::MODE_FINISH, 7'h00, 9'd0, 8'h00);
    endtask

    // Byte extremes move bit 7 into the status byte; the unused mode is skipped.
    task automatic test_byte_extremes();
        send_word(mnofc8_pkg::MODE_START, 7'h2A, 9'd5, 8'h00);
        send_word(mnofc8_pkg::MODE_DATA, 7'h00, 9'd0, 8'h00);
        send_word(mnofc8_pkg::MODE_DATA, 7'h7F, 9'h1FF, 8'hFF);
        send_word(mnofc8_pkg::MODE_DATA, 7'h00, 9'd0, 8'h80);
        send_word(mnofc8_pkg::MODE_DATA, 7'h00, 9'd0, 8'h7F);
        send_word(mnofc8_pkg::MODE_NONE, 7'h55, 9'h0AA, 8'hC3);
        send_word(mnofc8_pkg::MODE_DATA, 7'h00, 9'd0, 8'h01);
        send_word(mnofc8_pkg::MODE_FINISH, 7'h00, 9'd0, 8'h00);
    endtask

    task automatic test_random_transfers(input int word_goal, input bit with_pause);
        int         sent;
        int         n;
        bit         paused;
        logic [8:0] size;
        logic [1:0] mode;
        sent = 0;
        paused = 1'b0;
        while (sent < word_goal) begin
            if (with_pause && !paused && sent >= word_goal / 2) begin
                settle();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 85) begin
                size = ($urandom_range(19) == 0) ? 9'($urandom_range(0, 511))
                                                 : 9'($urandom_range(0, 12));
                n = (size <= 9'd12) ? int'(size) : $urandom_range(0, 12);
                if (size <= 9'd1) n = 0;
                if ($urandom_range(9) == 0) n = $urandom_range(0, 14);
                send_word(mnofc8_pkg::MODE_START, 7'($urandom), size, 8'($urandom));
                sent++;
                repeat (n) begin
                    send_word(mnofc8_pkg::MODE_DATA, 7'($urandom), 9'($urandom),
                              8'($urandom));
                    sent++;
                end
                if ($urandom_range(19) != 0) begin
                    send_word(mnofc8_pkg::MODE_FINISH, 7'($urandom), 9'($urandom),
                              8'($urandom));
                    sent++;
                end
            end else begin
                mode = 2'($urandom_range(0, 3));
                send_word(mode, 7'($urandom), 9'($urandom), 8'($urandom));
                if (mode != mnofc8_pkg::MODE_NONE) sent++;
            end
        end
    endtask

    // Polynomial extremes, a write to an unmapped address, and readback.
    task automatic test_register_access();
        write_register(ADDR_POLY, 8'h00);
        test_random_transfers(8, 1'b0);
        write_register(ADDR_POLY, 8'hFF);
        test_random_transfers(8, 1'b0);
        write_register(ADDR_UNUSED, 8'h5A);
        test_random_transfers(8, 1'b0);
    endtask

    initial begin
        logic [7:0] poly_plan[6];
        poly_plan = '{8'h07, 8'h00, 8'hFF, 8'h31, 8'h9B, 8'($urandom)};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_no_start();
        test_start_sizes();
        test_byte_extremes();
        test_register_access();
        foreach (poly_plan[i]) begin
            write_register(ADDR_POLY, poly_plan[i]);
            steady = (i == 2);
            test_random_transfers(300, i == 1);
        end
        steady = 1'b0;
        settle();
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mnofc8_pkg.sv
rtl/mnofc8_in_stage.sv
rtl/mnofc8_frame_stage.sv
rtl/midi_note_off_framer_crc8.sv
sim/midi_note_off_framer_crc8_tb.sv
